// File: rtl/q16va_pkg.sv
`timescale 1ns / 1ps

package q16va_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int CMDW      = 4;
  localparam int PW        = 2 * DW;

  // divider: dividend magnitude is |n| shifted left by the fraction bits
  localparam int DIVW = DW + FRAC_BITS;
  // square root of a non-negative sum shifted left by the fraction bits
  localparam int ROOTW = (DW + FRAC_BITS + 1) / 2;
  localparam int RADW  = 2 * ROOTW;
  localparam int REMW  = ROOTW + 2;

  // recurrence steps per pipeline stage
  localparam int STEPS = 4;
  localparam int SQS   = (ROOTW + STEPS - 1) / STEPS;
  localparam int DVS   = (DIVW + STEPS - 1) / STEPS;

  typedef enum logic [CMDW-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_SMUL = 4'd4,
    CMD_SDIV = 4'd5,
    CMD_ABS  = 4'd6,
    CMD_DOT  = 4'd7,
    CMD_CRS  = 4'd8,
    CMD_LEN  = 4'd9,
    CMD_NORM = 4'd10,
    CMD_MIN  = 4'd11,
    CMD_MAX  = 4'd12
  } cmd_t;

  typedef struct packed {
    logic [CMDW-1:0]        cmd;
    logic signed [DW-1:0]   ax;
    logic signed [DW-1:0]   ay;
    logic signed [DW-1:0]   bx;
    logic signed [DW-1:0]   by;
  } vec_req_t;

  typedef struct packed {
    logic signed [DW-1:0]   rx;
    logic signed [DW-1:0]   ry;
    logic                   math_error;
  } vec_rsp_t;

  // product stage
  typedef struct packed {
    logic [CMDW-1:0]        cmd;
    logic signed [DW-1:0]   ax;
    logic signed [DW-1:0]   ay;
    logic signed [DW-1:0]   bx;
    logic signed [DW-1:0]   by;
    logic signed [PW-1:0]   p0;
    logic signed [PW-1:0]   p1;
  } mul_t;

  // square root stages
  typedef struct packed {
    logic [CMDW-1:0]        cmd;
    logic signed [DW-1:0]   res_x;
    logic signed [DW-1:0]   res_y;
    logic                   err;
    logic signed [DW-1:0]   nx;
    logic signed [DW-1:0]   ny;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic [RADW-1:0]        rad;
    logic [ROOTW-1:0]       root;
    logic [REMW-1:0]        rem;
  } sq_t;

  // one divider lane: dividend bits shift out the top, quotient bits in the bottom
  typedef struct packed {
    logic [DIVW-1:0]        dd;
    logic [DW:0]            rem;
    logic [DW-1:0]          dm;
    logic                   neg;
    logic                   zero;
  } lane_t;

  typedef struct packed {
    logic                   is_div;
    logic signed [DW-1:0]   res_x;
    logic signed [DW-1:0]   res_y;
    logic                   err;
    lane_t                  lx;
    lane_t                  ly;
  } dv_t;

  // one digit of the restoring square root
  function automatic sq_t sq_step(sq_t s);
    sq_t             t;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    t      = s;
    rem_sh = {s.rem[REMW-3:0], s.rad[RADW-1:RADW-2]};
    trial  = {s.root, 2'b01};
    t.rad  = {s.rad[RADW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      t.rem  = rem_sh - trial;
      t.root = {s.root[ROOTW-2:0], 1'b1};
    end else begin
      t.rem  = rem_sh;
      t.root = {s.root[ROOTW-2:0], 1'b0};
    end
    return t;
  endfunction

  // divider lane set up from signed numerator and divisor
  function automatic lane_t lane_init(logic signed [DW-1:0] n, logic signed [DW-1:0] d);
    lane_t         l;
    logic [DW-1:0] nm;
    nm     = n[DW-1] ? DW'(-n) : DW'(n);
    l.dd   = {nm, {FRAC_BITS{1'b0}}};
    l.dm   = d[DW-1] ? DW'(-d) : DW'(d);
    l.rem  = '0;
    l.neg  = n[DW-1] ^ d[DW-1];
    l.zero = (d == '0);
    return l;
  endfunction

  // one bit of the restoring division
  function automatic lane_t lane_step(lane_t l);
    lane_t       t;
    logic [DW:0] rem_sh;
    t      = l;
    rem_sh = {l.rem[DW-1:0], l.dd[DIVW-1]};
    if (rem_sh >= {1'b0, l.dm}) begin
      t.rem = rem_sh - {1'b0, l.dm};
      t.dd  = {l.dd[DIVW-2:0], 1'b1};
    end else begin
      t.rem = rem_sh;
      t.dd  = {l.dd[DIVW-2:0], 1'b0};
    end
    return t;
  endfunction

  // signed, wrapped quotient of a finished lane
  function automatic logic signed [DW-1:0] lane_result(lane_t l);
    logic [DW-1:0] q;
    q = l.dd[DW-1:0];
    if (l.zero) begin
      return '0;
    end
    return l.neg ? $signed(-q) : $signed(q);
  endfunction

endpackage

// File: rtl/q16_vector_alu_core.sv
`timescale 1ns / 1ps

// channel | signals                        | transaction
// --------+--------------------------------+------------------------------------
// req     | req_valid, req_ready, req      | cmd, ax, ay, bx, by
// rsp     | rsp_valid, rsp_ready, rsp      | rx, ry, math_error
//
// every Q16.16 transaction passes through the square root stages followed by
// the divider stages, four steps each
// one transaction enters per cycle; the whole pipeline moves whenever rsp is
// empty or being taken, so a stall holds every stage in place
// rst clears only the valid bits

module q16_vector_alu_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  q16va_pkg::vec_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output q16va_pkg::vec_rsp_t rsp
);

  logic                 adv;
  q16va_pkg::vec_req_t  stg_in;
  logic                 in_vld;
  q16va_pkg::mul_t      stg_mul;
  q16va_pkg::mul_t      stg_mul_next;
  logic                 mul_vld;
  q16va_pkg::sq_t       sq_head;
  q16va_pkg::sq_t       sq_pipe [q16va_pkg::SQS+1];
  q16va_pkg::sq_t       sq_pipe_next [q16va_pkg::SQS+1];
  logic [q16va_pkg::SQS:0] sq_vld;
  q16va_pkg::dv_t       dv_head;
  q16va_pkg::dv_t       dv_pipe [q16va_pkg::DVS+1];
  q16va_pkg::dv_t       dv_pipe_next [q16va_pkg::DVS+1];
  logic [q16va_pkg::DVS:0] dv_vld;
  q16va_pkg::vec_rsp_t  rsp_next;

  // whole pipeline advances when the output slot frees
  assign adv       = ~rsp_valid | rsp_ready;
  assign req_ready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      mul_vld   <= 1'b0;
      sq_vld    <= '0;
      dv_vld    <= '0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      in_vld    <= req_valid;
      mul_vld   <= in_vld;
      sq_vld    <= {sq_vld[q16va_pkg::SQS-1:0], mul_vld};
      dv_vld    <= {dv_vld[q16va_pkg::DVS-1:0], sq_vld[q16va_pkg::SQS]};
      rsp_valid <= dv_vld[q16va_pkg::DVS];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      stg_in  <= req;
      stg_mul <= stg_mul_next;
      for (int k = 0; k <= q16va_pkg::SQS; k++) begin
        sq_pipe[k] <= sq_pipe_next[k];
      end
      for (int k = 0; k <= q16va_pkg::DVS; k++) begin
        dv_pipe[k] <= dv_pipe_next[k];
      end
      rsp <= rsp_next;
    end
  end

  // operand select and the two multipliers
  always_comb begin
    logic signed [q16va_pkg::DW-1:0] a0, b0, a1, b1;
    a0 = stg_in.ax;
    b0 = stg_in.bx;
    a1 = stg_in.ay;
    b1 = stg_in.by;
    unique case (stg_in.cmd)
      q16va_pkg::CMD_SMUL: b1 = stg_in.bx;
      q16va_pkg::CMD_CRS: begin
        b0 = stg_in.by;
        a1 = stg_in.bx;
        b1 = stg_in.ay;
      end
      q16va_pkg::CMD_LEN, q16va_pkg::CMD_NORM: begin
        b0 = stg_in.ax;
        b1 = stg_in.ay;
      end
      default: ;
    endcase
    stg_mul_next.cmd = stg_in.cmd;
    stg_mul_next.ax  = stg_in.ax;
    stg_mul_next.ay  = stg_in.ay;
    stg_mul_next.bx  = stg_in.bx;
    stg_mul_next.by  = stg_in.by;
    stg_mul_next.p0  = q16va_pkg::PW'(a0) * q16va_pkg::PW'(b0);
    stg_mul_next.p1  = q16va_pkg::PW'(a1) * q16va_pkg::PW'(b1);
  end

  // elementwise results, sum of squares, divider operands
  always_comb begin
    logic signed [q16va_pkg::DW-1:0] m0, m1, sum;
    q16va_pkg::sq_t s;
    m0  = stg_mul.p0[q16va_pkg::FRAC_BITS+q16va_pkg::DW-1:q16va_pkg::FRAC_BITS];
    m1  = stg_mul.p1[q16va_pkg::FRAC_BITS+q16va_pkg::DW-1:q16va_pkg::FRAC_BITS];
    sum = m0 + m1;
    s.cmd   = stg_mul.cmd;
    s.res_x = '0;
    s.res_y = '0;
    s.err   = 1'b0;
    s.nx    = stg_mul.ax;
    s.ny    = stg_mul.ay;
    s.dx    = stg_mul.bx;
    s.dy    = (stg_mul.cmd == q16va_pkg::CMD_SDIV) ? stg_mul.bx : stg_mul.by;
    s.rad   = '0;
    s.root  = '0;
    s.rem   = '0;
    unique case (stg_mul.cmd)
      q16va_pkg::CMD_ADD: begin
        s.res_x = stg_mul.ax + stg_mul.bx;
        s.res_y = stg_mul.ay + stg_mul.by;
      end
      q16va_pkg::CMD_SUB: begin
        s.res_x = stg_mul.ax - stg_mul.bx;
        s.res_y = stg_mul.ay - stg_mul.by;
      end
      q16va_pkg::CMD_MUL, q16va_pkg::CMD_SMUL: begin
        s.res_x = m0;
        s.res_y = m1;
      end
      q16va_pkg::CMD_ABS: begin
        s.res_x = stg_mul.ax[q16va_pkg::DW-1] ? -stg_mul.ax : stg_mul.ax;
        s.res_y = stg_mul.ay[q16va_pkg::DW-1] ? -stg_mul.ay : stg_mul.ay;
      end
      q16va_pkg::CMD_DOT: s.res_x = sum;
      q16va_pkg::CMD_CRS: s.res_x = m0 - m1;
      q16va_pkg::CMD_LEN, q16va_pkg::CMD_NORM: begin
        // negative wrapped sum: root of zero and the error flag
        s.err = sum[q16va_pkg::DW-1];
        if (!sum[q16va_pkg::DW-1]) begin
          s.rad = q16va_pkg::RADW'({sum, {q16va_pkg::FRAC_BITS{1'b0}}});
        end
      end
      q16va_pkg::CMD_MIN: begin
        s.res_x = (stg_mul.ax < stg_mul.bx) ? stg_mul.ax : stg_mul.bx;
        s.res_y = (stg_mul.ay < stg_mul.by) ? stg_mul.ay : stg_mul.by;
      end
      q16va_pkg::CMD_MAX: begin
        s.res_x = (stg_mul.ax > stg_mul.bx) ? stg_mul.ax : stg_mul.bx;
        s.res_y = (stg_mul.ay > stg_mul.by) ? stg_mul.ay : stg_mul.by;
      end
      default: ;
    endcase
    sq_head = s;
  end

  // square root stages
  always_comb begin
    q16va_pkg::sq_t t;
    sq_pipe_next[0] = sq_head;
    for (int k = 0; k < q16va_pkg::SQS; k++) begin
      t = sq_pipe[k];
      for (int j = 0; j < q16va_pkg::STEPS; j++) begin
        if (k * q16va_pkg::STEPS + j < q16va_pkg::ROOTW) begin
          t = q16va_pkg::sq_step(t);
        end
      end
      sq_pipe_next[k+1] = t;
    end
  end

  // divider set up: divisor is b, or the length for normalize
  always_comb begin
    q16va_pkg::sq_t s;
    q16va_pkg::dv_t d;
    logic signed [q16va_pkg::DW-1:0] len;
    s   = sq_pipe[q16va_pkg::SQS];
    len = $signed(q16va_pkg::DW'(s.root));
    d.is_div = 1'b0;
    d.res_x  = s.res_x;
    d.res_y  = s.res_y;
    d.err    = s.err;
    d.lx     = q16va_pkg::lane_init(s.nx, s.dx);
    d.ly     = q16va_pkg::lane_init(s.ny, s.dy);
    unique case (s.cmd)
      q16va_pkg::CMD_DIV, q16va_pkg::CMD_SDIV: begin
        d.is_div = 1'b1;
        d.err    = d.lx.zero | d.ly.zero;
      end
      q16va_pkg::CMD_LEN: d.res_x = len;
      q16va_pkg::CMD_NORM: begin
        // zero length gives the zero vector without a divide error
        d.is_div = 1'b1;
        d.lx     = q16va_pkg::lane_init(s.nx, len);
        d.ly     = q16va_pkg::lane_init(s.ny, len);
      end
      default: ;
    endcase
    dv_head = d;
  end

  // divider stages
  always_comb begin
    q16va_pkg::dv_t t;
    dv_pipe_next[0] = dv_head;
    for (int k = 0; k < q16va_pkg::DVS; k++) begin
      t = dv_pipe[k];
      for (int j = 0; j < q16va_pkg::STEPS; j++) begin
        if (k * q16va_pkg::STEPS + j < q16va_pkg::DIVW) begin
          t.lx = q16va_pkg::lane_step(t.lx);
          t.ly = q16va_pkg::lane_step(t.ly);
        end
      end
      dv_pipe_next[k+1] = t;
    end
  end

  // result select into the output register
  always_comb begin
    q16va_pkg::dv_t d;
    d = dv_pipe[q16va_pkg::DVS];
    rsp_next.math_error = d.err;
    if (d.is_div) begin
      rsp_next.rx = q16va_pkg::lane_result(d.lx);
      rsp_next.ry = q16va_pkg::lane_result(d.ly);
    end else begin
      rsp_next.rx = d.res_x;
      rsp_next.ry = d.res_y;
    end
  end

endmodule

// File: rtl/q16va_checker.sv
`timescale 1ns / 1ps

module q16va_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input q16va_pkg::vec_req_t req,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input q16va_pkg::vec_rsp_t rsp
);

  // a stalled response holds its transaction
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed under stall");

  // an empty output slot never blocks the input
  a_empty_ready: assert property (@(posedge clk)
    !rsp_valid |-> req_ready)
    else $error("input blocked with output empty");

  // a taken response frees the pipeline in the same cycle
  a_take_ready: assert property (@(posedge clk)
    rsp_ready |-> req_ready)
    else $error("input blocked while output taken");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind q16_vector_alu_core q16va_checker u_q16va_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// File: bench/q16_vector_alu_core_test.sv
`timescale 1ns / 1ps

module q16_vector_alu_core_test;

  localparam int          N_RANDOM      = 1780;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          HOLD_AT       = 600;
  localparam logic [3:0]  CMD_SPARE_LO  = 4'd13;
  localparam logic [3:0]  CMD_SPARE_HI  = 4'd15;
  localparam logic signed [31:0] ONE    = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV   = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV   = 32'sh8000_0000;
  // 181.0 squared twice overflows into a negative sum
  localparam logic signed [31:0] BIG    = 32'sh00b5_0000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  q16va_pkg::vec_req_t req = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  q16va_pkg::vec_rsp_t rsp;

  typedef struct {
    q16va_pkg::vec_req_t r;
    bit                  typed;
    q16va_pkg::vec_rsp_t e;
  } row_t;

  q16va_pkg::vec_rsp_t expected_q[$];
  row_t     rows[$];
  int       errors     = 0;
  int       sent       = 0;
  int       checked    = 0;
  int       cycles     = 0;
  int       per_cmd[16];

  q16_vector_alu_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #6 clk = ~clk;

  // fixed-point arithmetic mirrored at 64 bits
  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return 32'(p >>> q16va_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] qdiv(logic signed [31:0] a, logic signed [31:0] b,
                                              inout logic err);
    longint n;
    if (b == 0) begin
      err = 1'b1;
      return '0;
    end
    n = longint'(a) * (longint'(1) <<< q16va_pkg::FRAC_BITS);
    return 32'(n / longint'(b));
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] qlen(logic signed [31:0] x, logic signed [31:0] y,
                                              inout logic err);
    logic signed [31:0] s;
    s = qmul(x, x) + qmul(y, y);
    if (s < 0) begin
      err = 1'b1;
      return '0;
    end
    return 32'(floor_root(longint'(s) << q16va_pkg::FRAC_BITS));
  endfunction

  // expected response of one request
  function automatic q16va_pkg::vec_rsp_t alu_predict(q16va_pkg::vec_req_t r);
    q16va_pkg::vec_rsp_t o;
    logic                e;
    logic signed [31:0]  len;
    o = '0;
    e = 1'b0;
    case (r.cmd)
      q16va_pkg::CMD_ADD: begin
        o.rx = r.ax + r.bx;  o.ry = r.ay + r.by;
      end
      q16va_pkg::CMD_SUB: begin
        o.rx = r.ax - r.bx;  o.ry = r.ay - r.by;
      end
      q16va_pkg::CMD_MUL: begin
        o.rx = qmul(r.ax, r.bx);  o.ry = qmul(r.ay, r.by);
      end
      q16va_pkg::CMD_DIV: begin
        o.rx = qdiv(r.ax, r.bx, e);  o.ry = qdiv(r.ay, r.by, e);
      end
      q16va_pkg::CMD_SMUL: begin
        o.rx = qmul(r.ax, r.bx);  o.ry = qmul(r.ay, r.bx);
      end
      q16va_pkg::CMD_SDIV: begin
        o.rx = qdiv(r.ax, r.bx, e);  o.ry = qdiv(r.ay, r.bx, e);
      end
      q16va_pkg::CMD_ABS: begin
        o.rx = r.ax < 0 ? -r.ax : r.ax;
        o.ry = r.ay < 0 ? -r.ay : r.ay;
      end
      q16va_pkg::CMD_DOT: o.rx = qmul(r.ax, r.bx) + qmul(r.ay, r.by);
      q16va_pkg::CMD_CRS: o.rx = qmul(r.ax, r.by) - qmul(r.bx, r.ay);
      q16va_pkg::CMD_LEN: o.rx = qlen(r.ax, r.ay, e);
      q16va_pkg::CMD_NORM: begin
        len = qlen(r.ax, r.ay, e);
        if (len != 0) begin
          o.rx = qdiv(r.ax, len, e);
          o.ry = qdiv(r.ay, len, e);
        end
      end
      q16va_pkg::CMD_MIN: begin
        o.rx = r.ax < r.bx ? r.ax : r.bx;  o.ry = r.ay < r.by ? r.ay : r.by;
      end
      q16va_pkg::CMD_MAX: begin
        o.rx = r.ax > r.bx ? r.ax : r.bx;  o.ry = r.ay > r.by ? r.ay : r.by;
      end
      default: o = '0;
    endcase
    o.math_error = e;
    return o;
  endfunction

  function automatic void add_row(logic [3:0] c, logic signed [31:0] ax, logic signed [31:0] ay,
                                  logic signed [31:0] bx, logic signed [31:0] by, bit typed,
                                  logic signed [31:0] rx = 0, logic signed [31:0] ry = 0,
                                  logic er = 0);
    row_t w;
    w.r     = '{cmd: c, ax: ax, ay: ay, bx: bx, by: by};
    w.typed = typed;
    w.e     = '{rx: rx, ry: ry, math_error: er};
    rows.push_back(w);
  endfunction

  // operand mix: full range, small values, extremes
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      7:          return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return MAXV;
          1: return MINV;
          2: return '0;
          3: return ONE;
          4: return -ONE;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // one request held until accepted, then its expectation is queued
  task automatic send(row_t w);
    req       <= w.r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_q.push_back(w.typed ? w.e : alu_predict(w.r));
    per_cmd[w.r.cmd]++;
    sent++;
  endtask

  task automatic wait_empty();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    row_t w;
    int   burst;
    int   k;
    int   i;
    foreach (per_cmd[j]) per_cmd[j] = 0;
    add_row(q16va_pkg::CMD_ADD, ONE, -ONE, 2 * ONE, ONE / 2, 1, 3 * ONE, -(ONE / 2), 0);
    add_row(q16va_pkg::CMD_ADD, MAXV, MINV, ONE >>> 16, -32'sd1, 1, MINV, MAXV, 0);
    add_row(q16va_pkg::CMD_SUB, MINV, MAXV, 32'sd1, -32'sd1, 1, MAXV, MINV, 0);
    add_row(q16va_pkg::CMD_MUL, 2 * ONE, -ONE, 3 * ONE, 5 * ONE, 0);
    add_row(q16va_pkg::CMD_MUL, MINV, MAXV, MINV, MAXV, 0);
    add_row(q16va_pkg::CMD_DIV, ONE, ONE, 0, 0, 1, 0, 0, 1);
    add_row(q16va_pkg::CMD_DIV, ONE, MINV, 2 * ONE, -ONE, 0);
    add_row(q16va_pkg::CMD_SMUL, MAXV, -3 * ONE, ONE / 4, 7, 0);
    add_row(q16va_pkg::CMD_SDIV, ONE, -ONE, 0, ONE, 1, 0, 0, 1);
    add_row(q16va_pkg::CMD_SDIV, MAXV, MINV, 3, 0, 0);
    add_row(q16va_pkg::CMD_ABS, MINV, -ONE, 5, 5, 1, MINV, ONE, 0);
    add_row(q16va_pkg::CMD_DOT, 3 * ONE, MINV, -ONE, MAXV, 0);
    add_row(q16va_pkg::CMD_CRS, MAXV, 2 * ONE, MINV, -ONE, 0);
    add_row(q16va_pkg::CMD_LEN, 3 * ONE, 4 * ONE, 0, 0, 1, 5 * ONE, 0, 0);
    add_row(q16va_pkg::CMD_LEN, BIG, BIG, 0, 0, 1, 0, 0, 1);
    add_row(q16va_pkg::CMD_NORM, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(q16va_pkg::CMD_NORM, 3 * ONE, -4 * ONE, 0, 0, 0);
    add_row(q16va_pkg::CMD_NORM, BIG, -BIG, 0, 0, 1, 0, 0, 1);
    add_row(q16va_pkg::CMD_NORM, 1, 0, 0, 0, 0);
    add_row(q16va_pkg::CMD_MIN, MINV, MAXV, MAXV, MINV, 1, MINV, MINV, 0);
    add_row(q16va_pkg::CMD_MAX, MINV, MAXV, MAXV, MINV, 1, MAXV, MAXV, 0);
    add_row(CMD_SPARE_LO, MAXV, MINV, ONE, ONE, 1, 0, 0, 0);
    add_row(CMD_SPARE_HI, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, back to back
    foreach (rows[j]) send(rows[j]);
    req_valid <= 1'b0;
    wait_empty();

    // random requests in bursts
    i = 0;
    while (i < N_RANDOM) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (k = 0; k < burst && i < N_RANDOM; k++) begin
        w.typed = 0;
        w.e     = '0;
        w.r.cmd = ($urandom_range(0, 15) == 0)
                  ? 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))
                  : 4'($urandom_range(q16va_pkg::CMD_ADD, q16va_pkg::CMD_MAX));
        w.r.ax  = pick_operand();
        w.r.ay  = pick_operand();
        w.r.bx  = pick_operand();
        w.r.by  = pick_operand();
        send(w);
        i++;
      end
      // a gap between most bursts, sometimes a full drain
      if (i < N_RANDOM) begin
        if (i % 500 < burst) begin
          req_valid <= 1'b0;
          wait_empty();
        end else if ($urandom_range(0, 2) != 0) begin
          req_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
    req_valid <= 1'b0;

    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d responses checked, per opcode:", sent, checked);
    $display("  %p", per_cmd);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // response side stall pattern with one long hold-off
  initial begin
    int  mode;
    int  left;
    bit  held;
    mode = 0;
    left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && sent >= HOLD_AT) begin
        held = 1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0:       rsp_ready <= 1'b1;
          1:       rsp_ready <= $urandom_range(0, 1);
          2:       rsp_ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // response checking
  always @(posedge clk) begin
    q16va_pkg::vec_rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction rx=%h ry=%h err=%b", $time, rsp.rx, rsp.ry,
                 rsp.math_error);
        errors++;
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (rsp.rx !== e.rx) begin
          $display("%0t: rx expected %h actual %h", $time, e.rx, rsp.rx);
          errors++;
        end
        if (rsp.ry !== e.ry) begin
          $display("%0t: ry expected %h actual %h", $time, e.ry, rsp.ry);
          errors++;
        end
        if (rsp.math_error !== e.math_error) begin
          $display("%0t: math_error expected %b actual %b", $time, e.math_error,
                   rsp.math_error);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycles,
               expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

// File: q16_vector_alu_core.f
rtl/q16va_pkg.sv
rtl/q16_vector_alu_core.sv
rtl/q16va_checker.sv
bench/q16_vector_alu_core_test.sv
